// File: rtl/sacrr_pkg.sv
// shared constants for the set-associative round-robin cache
package sacrr_pkg;

  localparam int SET_COUNT   = 8;
  localparam int WAY_COUNT   = 4;
  localparam int OFFSET_BITS = 5;

  localparam int ADDR_W    = 32;
  localparam int CFG_LAT_W = 8;
  localparam int LAT_W     = 9;
  localparam int CNT_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOOKUP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_READ   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE  = 2'd3;

  localparam logic                 RST_ENABLE = 1'b1;
  localparam logic [CFG_LAT_W-1:0] RST_LOOKUP = 8'd1;
  localparam logic [CFG_LAT_W-1:0] RST_READ   = 8'd10;
  localparam logic [CFG_LAT_W-1:0] RST_WRITE  = 8'd10;

  // access kinds
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

endpackage

// File: rtl/sacrr_if.sv
// request and response channel interfaces of the cache
interface sacrr_req_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [sacrr_pkg::ADDR_W-1:0] addr;

  modport source(output valid, kind, addr, input ready);
  modport sink(input valid, kind, addr, output ready);
endinterface

interface sacrr_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        writeback;
  logic [sacrr_pkg::LAT_W-1:0] latency;
  logic [sacrr_pkg::CNT_W-1:0] load_count;
  logic [sacrr_pkg::CNT_W-1:0] store_count;
  logic [sacrr_pkg::CNT_W-1:0] load_miss_count;
  logic [sacrr_pkg::CNT_W-1:0] store_miss_count;
  logic [sacrr_pkg::CNT_W-1:0] writeback_count;

  modport source(output valid, hit, writeback, latency, load_count, store_count,
                 load_miss_count, store_miss_count, writeback_count, input ready);
  modport sink(input valid, hit, writeback, latency, load_count, store_count,
               load_miss_count, store_miss_count, writeback_count, output ready);
endinterface

// File: rtl/set_assoc_cache_round_robin.sv
// set-associative write-back cache model with round-robin replacement
// one access at a time: accept, set memory read, then update and result
// a set count that is not a power of two adds the ST_DIV state when enabled: reciprocal multiply, then remainder
// the set memory has one port, so an access finishes before the next is read
// after reset a clearing pass writes every set row, with no access taken
// registers reset to enable 1, lookup 1, read 10, write 10; counters reset to zero
module set_assoc_cache_round_robin #(
  parameter int SET_COUNT   = sacrr_pkg::SET_COUNT,
  parameter int WAY_COUNT   = sacrr_pkg::WAY_COUNT,
  parameter int OFFSET_BITS = sacrr_pkg::OFFSET_BITS
) (
  input  logic                            clk,
  input  logic                            rst,
  sacrr_req_if.sink                       req,
  sacrr_rsp_if.source                     rsp,
  input  logic                            cfg_we,
  input  logic [sacrr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sacrr_pkg::CFG_W-1:0]     cfg_data
);

  localparam int  BLOCK_W  = sacrr_pkg::ADDR_W - OFFSET_BITS;
  localparam int  SET_W    = $clog2(SET_COUNT);
  localparam int  TAG_W    = BLOCK_W - ($clog2(SET_COUNT + 1) - 1);
  localparam int  PTR_W    = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int  PROD_W   = 2 * BLOCK_W + 1;
  localparam int  REC_SH   = BLOCK_W + SET_W;
  localparam bit  SET_POW2 = ((SET_COUNT & (SET_COUNT - 1)) == 0);

  // ceil(2^REC_SH / SET_COUNT) gives the exact quotient for every block number
  localparam logic [63:0]      REC_ONE = 64'd1 << REC_SH;
  localparam logic [BLOCK_W:0] REC_MUL =
    (BLOCK_W + 1)'((REC_ONE + 64'(SET_COUNT - 1)) / 64'(SET_COUNT));

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [TAG_W-1:0] tag;
  } line_t;

  typedef struct packed {
    logic [PTR_W-1:0]            ptr;
    line_t [WAY_COUNT-1:0]       line;
  } row_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_DIV    = 5'b00100,
    ST_READ   = 5'b01000,
    ST_UPDATE = 5'b10000
  } state_t;

  state_t state, state_next;

  // configuration
  logic                              cfg_enable;
  logic [sacrr_pkg::CFG_LAT_W-1:0]   cfg_lookup, cfg_read, cfg_write;

  // captured access
  logic                 kind_q;
  logic                 en_q;
  logic [BLOCK_W-1:0]   div_blk;
  logic [SET_W-1:0]     div_rem;
  logic [BLOCK_W-1:0]   div_quo;
  logic                 div_phase;
  logic [SET_W-1:0]     clr_idx;

  // set memory
  row_t                 mem [SET_COUNT];
  row_t                 rd_row;
  row_t                 wr_row;
  logic                 mem_we;
  logic [SET_W-1:0]     mem_addr;

  // result and counters
  logic                       out_valid, out_hit, out_wb;
  logic [sacrr_pkg::LAT_W-1:0] out_lat;
  logic [sacrr_pkg::CNT_W-1:0] load_cnt, store_cnt, load_miss_cnt, store_miss_cnt, wb_cnt;

  logic                       acc_fire, upd_fire;
  logic [BLOCK_W-1:0]         acc_block;
  logic [PROD_W-1:0]          rec_prod;
  logic [TAG_W-1:0]           tag_cur;
  logic [WAY_COUNT-1:0]       hit_vec;
  logic                       hit_any;
  logic                       victim_dirty;
  logic [sacrr_pkg::LAT_W-1:0] lat_res;

  assign acc_fire  = req.valid && req.ready;
  assign upd_fire  = (state == ST_UPDATE) && (!out_valid || rsp.ready);
  assign acc_block = req.addr[sacrr_pkg::ADDR_W-1:OFFSET_BITS];
  assign tag_cur   = div_blk[TAG_W-1:0];

  // set/tag split by reciprocal multiplication: quotient first, remainder next cycle
  assign rec_prod = PROD_W'(div_blk) * PROD_W'(REC_MUL);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_idx == SET_W'(SET_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (acc_fire) state_next = (SET_POW2 || !cfg_enable) ? ST_READ : ST_DIV;
      end
      ST_DIV: begin
        if (div_phase) state_next = ST_READ;
      end
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (upd_fire) state_next = ST_IDLE;
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_idx <= '0;
    end else if (state == ST_CLEAR) begin
      clr_idx <= clr_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_enable <= sacrr_pkg::RST_ENABLE;
      cfg_lookup <= sacrr_pkg::RST_LOOKUP;
      cfg_read   <= sacrr_pkg::RST_READ;
      cfg_write  <= sacrr_pkg::RST_WRITE;
    end else if (cfg_we) begin
      case (cfg_index)
        sacrr_pkg::REG_ENABLE: cfg_enable <= cfg_data[0];
        sacrr_pkg::REG_LOOKUP: cfg_lookup <= cfg_data;
        sacrr_pkg::REG_READ:   cfg_read   <= cfg_data;
        sacrr_pkg::REG_WRITE:  cfg_write  <= cfg_data;
        default: ;
      endcase
    end
  end

  // access capture and set/tag split
  always_ff @(posedge clk) begin
    if (acc_fire) begin
      kind_q    <= req.kind;
      en_q      <= cfg_enable;
      div_phase <= 1'b0;
      if (SET_POW2) begin
        div_blk <= BLOCK_W'(acc_block >> SET_W);
        div_rem <= acc_block[SET_W-1:0];
      end else begin
        div_blk <= acc_block;
        div_rem <= '0;
      end
    end else if (state == ST_DIV) begin
      div_phase <= 1'b1;
      if (!div_phase) begin
        div_quo <= BLOCK_W'(rec_prod >> REC_SH);
      end else begin
        // remainder fits the set index, so only its low bits are formed
        div_rem <= SET_W'(div_blk[SET_W-1:0] -
                          SET_W'(div_quo[SET_W-1:0] * SET_W'(SET_COUNT)));
        div_blk <= div_quo;
      end
    end
  end

  // lookup on the row read from memory
  always_comb begin
    hit_vec = '0;
    for (int j = 0; j < WAY_COUNT; j++) begin
      hit_vec[j] = rd_row.line[j].valid && (rd_row.line[j].tag == tag_cur);
    end
    hit_any      = |hit_vec;
    victim_dirty = rd_row.line[rd_row.ptr].dirty;

    wr_row = rd_row;
    if (hit_any) begin
      for (int j = 0; j < WAY_COUNT; j++) begin
        wr_row.line[j].dirty = rd_row.line[j].dirty | (hit_vec[j] & kind_q);
      end
    end else begin
      wr_row.line[rd_row.ptr].valid = 1'b1;
      wr_row.line[rd_row.ptr].dirty = kind_q;
      wr_row.line[rd_row.ptr].tag   = tag_cur;
      wr_row.ptr = (rd_row.ptr == PTR_W'(WAY_COUNT - 1)) ? '0 : rd_row.ptr + 1'b1;
    end

    if (!en_q) begin
      lat_res = (kind_q == sacrr_pkg::KIND_STORE) ? {1'b0, cfg_write} : {1'b0, cfg_read};
    end else if (hit_any) begin
      lat_res = {1'b0, cfg_lookup};
    end else if (victim_dirty) begin
      lat_res = {1'b0, cfg_read} + {1'b0, cfg_write};
    end else begin
      lat_res = {1'b0, cfg_read};
    end

    mem_we   = (state == ST_CLEAR) || (upd_fire && en_q);
    mem_addr = (state == ST_CLEAR) ? clr_idx : div_rem;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_addr] <= (state == ST_CLEAR) ? row_t'('0) : wr_row;
    if (state == ST_READ) rd_row <= mem[div_rem];
  end

  // result and statistics
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      load_cnt       <= '0;
      store_cnt      <= '0;
      load_miss_cnt  <= '0;
      store_miss_cnt <= '0;
      wb_cnt         <= '0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
      if (en_q) begin
        if (kind_q == sacrr_pkg::KIND_STORE) store_cnt <= store_cnt + 1'b1;
        else                                 load_cnt  <= load_cnt + 1'b1;
        if (!hit_any) begin
          if (kind_q == sacrr_pkg::KIND_STORE) store_miss_cnt <= store_miss_cnt + 1'b1;
          else                                 load_miss_cnt  <= load_miss_cnt + 1'b1;
          if (victim_dirty) wb_cnt <= wb_cnt + 1'b1;
        end
      end
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      out_hit <= en_q && hit_any;
      out_wb  <= en_q && !hit_any && victim_dirty;
      out_lat <= lat_res;
    end
  end

  assign req.ready            = (state == ST_IDLE);
  assign rsp.valid            = out_valid;
  assign rsp.hit              = out_hit;
  assign rsp.writeback        = out_wb;
  assign rsp.latency          = out_lat;
  assign rsp.load_count       = load_cnt;
  assign rsp.store_count      = store_cnt;
  assign rsp.load_miss_count  = load_miss_cnt;
  assign rsp.store_miss_count = store_miss_cnt;
  assign rsp.writeback_count  = wb_cnt;

  a_result_from_update: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_UPDATE))
    else $error("result raised without an update");

  a_hit_no_writeback: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(out_hit && out_wb))
    else $error("hit and writeback both set");

  a_one_access_counted: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && en_q) |=> (sacrr_pkg::CNT_W'(load_cnt + store_cnt) ==
                            sacrr_pkg::CNT_W'($past(load_cnt + store_cnt) + 1'b1)))
    else $error("access count did not advance by one");

  a_bypass_keeps_counts: assert property (@(posedge clk) disable iff (rst)
    (upd_fire && !en_q) |=> ($stable(load_cnt) && $stable(store_cnt) && $stable(wb_cnt)))
    else $error("uncached access changed a counter");

  a_no_write_while_busy_read: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> !mem_we)
    else $error("set memory written during its read");

endmodule
